// File: rtl/core/magma_pkg.sv
// Shared types, constants and the round function of the Magma counter-mode keystream block.
// Used by magma_round_cell and magma_ctr_keystream_xor_top; depends on nothing else.
package magma_pkg;

  localparam int NUM_ROUNDS = 32;
  localparam int ROT_AMOUNT = 11;
  localparam int CFG_IDX_W  = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_KEY_WORD_0    = 3'd0;
  localparam cfg_idx_t CFG_KEY_WORD_1    = 3'd1;
  localparam cfg_idx_t CFG_KEY_WORD_2    = 3'd2;
  localparam cfg_idx_t CFG_KEY_WORD_3    = 3'd3;
  localparam cfg_idx_t CFG_COUNTER_START = 3'd4;

  localparam logic [3:0] FULL_COUNT = 4'd8;

  typedef struct packed {
    logic [63:0] block_data;
    logic [3:0]  byte_count;
    logic        restart;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] out_data;
    logic [3:0]  out_byte_count;
  } out_beat_t;

  // Payload that travels down the row of round cells.
  typedef struct packed {
    logic [31:0] hi;
    logic [31:0] lo;
    logic [63:0] data;
    logic [3:0]  count;
  } cell_beat_t;

  localparam logic [3:0] SBOX [8][16] = '{
    '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
      4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
    '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
      4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
    '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
      4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
    '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
      4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
    '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
      4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
    '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
      4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
    '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
      4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
    '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
      4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
  };

  // Subkey addition, eight S-boxes (first box on the lowest nibble), rotate left.
  function automatic logic [31:0] round_fn(input logic [31:0] half, input logic [31:0] subkey);
    logic [31:0] s;
    logic [31:0] t;
    s = half + subkey;
    for (int n = 0; n < 8; n++) begin
      t[4*n +: 4] = SBOX[n][s[4*n +: 4]];
    end
    return {t[31-ROT_AMOUNT:0], t[31:32-ROT_AMOUNT]};
  endfunction

  // Keeps the first count bytes, counted from the top of the word.
  function automatic logic [63:0] byte_mask(input logic [3:0] count);
    logic [63:0] m;
    for (int i = 0; i < 8; i++) begin
      m[63-8*i -: 8] = (4'(i) < count) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// File: rtl/core/magma_round_cell.sv
// One Feistel round of Magma as a pipeline cell with its own valid bit.
// Depends on magma_pkg for the beat type and the round function.
module magma_round_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            subkey,
  input  logic                   up_valid,
  input  magma_pkg::cell_beat_t  up_beat,
  output logic                   up_ready,
  output logic                   valid,
  output magma_pkg::cell_beat_t  beat,
  input  logic                   down_ready
);

  magma_pkg::cell_beat_t beat_next;

  // The cell can take a beat when it is empty or its own beat moves on.
  assign up_ready = !valid || down_ready;

  always_comb begin
    beat_next       = up_beat;
    beat_next.hi    = up_beat.lo;
    beat_next.lo    = magma_pkg::round_fn(up_beat.lo, subkey) ^ up_beat.hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      beat <= beat_next;
    end
  end

endmodule

// File: rtl/core/magma_ctr_keystream_xor_top.sv
// Top level of the Magma counter-mode keystream block: configuration, counter,
// a row of 32 round cells and the output register. Depends on magma_pkg and magma_round_cell.
//
//  Channel  | Signals                         | Payload
//  ---------+---------------------------------+--------------------------------
//  input    | in_valid, in_stall, in_beat     | block_data, byte_count, restart
//  output   | out_valid, out_stall, out_beat  | out_data, out_byte_count
//  config   | cfg_wr_en, cfg_index, cfg_data  | five 64-bit registers
//
// One beat is taken per clock cycle while in_stall is low. A beat passes through the 32 round
// cells and then the output register that applies the XOR and the byte mask.
// Reset clears the valid bits, the configuration registers and the block counter.
// Each cell holds its beat while the next stage is full and stalled, so empty
// cells close up behind a stalled output and the input keeps being taken
// until every cell and the output register hold a beat.
module magma_ctr_keystream_xor_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  magma_pkg::cfg_idx_t     cfg_index,
  input  logic [63:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  magma_pkg::in_beat_t     in_beat,
  output logic                    out_valid,
  input  logic                    out_stall,
  output magma_pkg::out_beat_t    out_beat
);

  localparam int N = magma_pkg::NUM_ROUNDS;

  logic [63:0] key_word [4];
  logic [63:0] counter_start;
  logic [63:0] block_counter;
  logic [63:0] ctr_used;

  logic                  cell_valid [N+1];
  magma_pkg::cell_beat_t cell_beat  [N+1];
  logic                  cell_ready [N+1];

  logic [63:0] gamma;
  logic        out_ready;
  logic        in_accept;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        key_word[i] <= '0;
      end
      counter_start <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        magma_pkg::CFG_KEY_WORD_0:    key_word[0]   <= cfg_data;
        magma_pkg::CFG_KEY_WORD_1:    key_word[1]   <= cfg_data;
        magma_pkg::CFG_KEY_WORD_2:    key_word[2]   <= cfg_data;
        magma_pkg::CFG_KEY_WORD_3:    key_word[3]   <= cfg_data;
        magma_pkg::CFG_COUNTER_START: counter_start <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall  = !cell_ready[0];
  assign in_accept = in_valid && cell_ready[0];
  assign ctr_used  = in_beat.restart ? counter_start : block_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
    end else if (in_accept) begin
      block_counter <= ctr_used + 64'd1;
    end
  end

  // Entry to the row: the counter to encrypt, the data and the saturated count.
  always_comb begin
    cell_valid[0]      = in_valid;
    cell_beat[0].hi    = ctr_used[63:32];
    cell_beat[0].lo    = ctr_used[31:0];
    cell_beat[0].data  = in_beat.block_data;
    cell_beat[0].count = (in_beat.byte_count > magma_pkg::FULL_COUNT)
                         ? magma_pkg::FULL_COUNT : in_beat.byte_count;
  end

  for (genvar r = 0; r < N; r++) begin : g_round
    // K1..K8 three times, then K8..K1.
    localparam int KI = (r < 24) ? (r % 8) : (31 - r);
    localparam int KW = KI / 2;
    logic [31:0] subkey;

    assign subkey = (KI % 2 == 1) ? key_word[KW][31:0] : key_word[KW][63:32];

    magma_round_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .subkey     (subkey),
      .up_valid   (cell_valid[r]),
      .up_beat    (cell_beat[r]),
      .up_ready   (cell_ready[r]),
      .valid      (cell_valid[r+1]),
      .beat       (cell_beat[r+1]),
      .down_ready (cell_ready[r+1])
    );
  end

  // After the last round the halves stand swapped relative to the cipher output.
  assign gamma         = {cell_beat[N].lo, cell_beat[N].hi};
  assign out_ready     = !out_valid || !out_stall;
  assign cell_ready[N] = out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= cell_valid[N];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && cell_valid[N]) begin
      out_beat.out_data       <= (cell_beat[N].data ^ gamma)
                                 & magma_pkg::byte_mask(cell_beat[N].count);
      out_beat.out_byte_count <= cell_beat[N].count;
    end
  end

endmodule
